// ----- hw/rtl/slid_pkg.sv -----
// Shared constants and types for the shift list insert/delete unit.
`timescale 1ns / 1ps

package slid_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] SH_NOP = 2'd0;
  localparam logic [1:0] SH_INS = 2'd1;
  localparam logic [1:0] SH_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } shift_cmd_t;

endpackage

// ----- hw/rtl/slid_cell.sv -----
// One list cell: holds one word and takes it from a neighbor or the request.
`timescale 1ns / 1ps

module slid_cell
  import slid_pkg::*;
(
  input  logic              clk,
  input  shift_cmd_t        cmd,
  input  logic [IDX_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data_q
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      SH_INS: begin
        if (idx == cmd.pos) begin
          data_nxt = cmd.val;
        end else if (idx > cmd.pos) begin
          data_nxt = left_data;
        end
      end
      SH_DEL: begin
        if (idx >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ----- hw/rtl/shift_list_insert_delete_unit.sv -----
// Top level of the shift list insert/delete unit: request decode, cell row, result register.
//
// Channel  Direction  Handshake              Contents
// in       slave      in_tvalid/in_tready    tuser: kind; tdata: position, value
// out      master     out_tvalid/out_tready  tdata: status, removed_value, count
// cfg      slave      cfg_valid/cfg_ready    capacity
//
// Each request is decoded and applied to every cell of the row as it is accepted.
// Its result appears in the output register on the following cycle.
// A new transaction is taken whenever the output register is empty or is
// being emptied, so the unit sustains one request per cycle.
// Reset clears the count and sets capacity to the built depth; cell contents
// stay undefined until written.
`timescale 1ns / 1ps

module shift_list_insert_delete_unit
  import slid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic [39:0] in_tdata,   // position[3:0], value[35:4], zero[39:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], removed_value[33:2], count[38:34], zero[39]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity[4:0]
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [DATA_W-1:0] removed_r;
  logic [DATA_W-1:0] removed_nxt;
  logic [CNT_W-1:0]  out_count_r;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  pos_ext;
  logic [3:0]        in_pos;
  logic [DATA_W-1:0] in_val;
  logic              in_fire;
  shift_cmd_t        cmd;
  logic [DATA_W-1:0] cell_q [DEPTH];

  assign in_pos    = in_tdata[3:0];
  assign in_val    = in_tdata[35:4];
  assign pos_ext   = CNT_W'(in_pos);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign lim       = (cap_r < DEPTH_C) ? cap_r : DEPTH_C;

  always_comb begin
    status_nxt  = ST_DONE;
    removed_nxt = '0;
    count_nxt   = count_r;
    cmd.op      = SH_NOP;
    cmd.pos     = IDX_W'(in_pos);
    cmd.val     = in_val;
    case (in_tuser)
      KIND_APPEND: begin
        if (count_r < lim) begin
          cmd.op    = SH_INS;
          cmd.pos   = count_r[IDX_W-1:0];
          count_nxt = count_r + 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      KIND_INSERT: begin
        if (pos_ext > count_r) begin
          status_nxt = ST_RANGE;
        end else if (count_r >= lim) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = SH_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_ext >= count_r || pos_ext >= DEPTH_C) begin
          status_nxt = ST_RANGE;
        end else begin
          cmd.op      = SH_DEL;
          removed_nxt = cell_q[IDX_W'(in_pos)];
          count_nxt   = count_r - 1'b1;
        end
      end
      default: status_nxt = ST_DONE;
    endcase
    if (!in_fire) begin
      cmd.op = SH_NOP;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end
    slid_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= DEPTH_C;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      removed_r   <= removed_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, removed_r, status_r};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_out_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r == count_r)
    else $error("reported count differs from held count");

  a_removed_done : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && removed_r != '0) |-> status_r == ST_DONE)
    else $error("removed value on a rejected request");

  a_reject_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && status_nxt != ST_DONE) |=> $stable(count_r))
    else $error("rejected request changed the count");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the shift list insert/delete unit.
`timescale 1ns / 1ps

module testbench
  import slid_pkg::*;
();

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         HOLD_AT      = 500;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  pos;
    logic [31:0] val;
  } list_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed;
    logic [4:0]  count;
  } list_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = 2'd0;   // kind[1:0]
  logic [39:0] in_tdata   = 40'd0;  // position[3:0], value[35:4], zero[39:36]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // status[1:0], removed_value[33:2], count[38:34], zero[39]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = 5'd0;   // capacity[4:0]

  list_req_t    pending_reqs[$];
  list_result_t awaited_results[$];

  logic [31:0] shadow_words [DEPTH];
  int          shadow_count;
  logic [4:0]  shadow_capacity;

  bit quiet_tail    = 1'b0;
  bit offering      = 1'b0;
  int accepted_reqs = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int recv_gap      = 0;
  int recv_calm     = 0;
  int rx_hold_left  = 0;
  bit rx_hold_done  = 1'b0;
  int errors        = 0;
  int cycle_count   = 0;
  int cap_writes    = 0;
  int status_seen [4];

  shift_list_insert_delete_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int lim;
    int i;
    res = '0;
    res.status = ST_DONE;
    lim = (int'(shadow_capacity) < DEPTH) ? int'(shadow_capacity) : DEPTH;
    case (r.kind)
      KIND_APPEND: begin
        if (shadow_count < lim) begin
          shadow_words[shadow_count] = r.val;
          shadow_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_INSERT: begin
        if (int'(r.pos) > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > int'(r.pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[r.pos] = r.val;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        if (int'(r.pos) >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          res.removed = shadow_words[r.pos];
          for (i = int'(r.pos); i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[4:0];
    return res;
  endfunction

  function automatic list_req_t random_request(bit grow);
    list_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) r.kind = KIND_UNUSED;
    else if (pick < (grow ? 48 : 18)) r.kind = KIND_APPEND;
    else if (pick < (grow ? 80 : 40)) r.kind = KIND_INSERT;
    else r.kind = KIND_DELETE;
    r.pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
    case ($urandom_range(0, 15))
      0: r.val = 32'h8000_0000;
      1: r.val = 32'h7FFF_FFFF;
      2: r.val = 32'h0000_0000;
      3: r.val = 32'hFFFF_FFFF;
      default: r.val = $urandom;
    endcase
    return r;
  endfunction

  task automatic queue_request(input logic [1:0] kind, input logic [3:0] pos,
                               input logic [31:0] val);
    list_req_t r;
    r.kind = kind;
    r.pos  = pos;
    r.val  = val;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (pending_reqs.size() != 0 || offering || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Request driver; the shadow list is updated on every accepted transaction.
  always @(posedge clk) begin
    list_req_t seen_req;
    list_req_t next_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      shadow_count = 0;
      shadow_capacity = 5'(DEPTH);
    end else begin
      if (cfg_valid && cfg_ready) shadow_capacity = cfg_data;
      if (in_tvalid && in_tready) begin
        seen_req = {in_tuser, in_tdata[3:0], in_tdata[35:4]};
        awaited_results.push_back(apply_request(seen_req));
        accepted_reqs <= accepted_reqs + 1;
        offering = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          offering = 1'b1;
          in_tvalid <= 1'b1;
          in_tuser  <= next_req.kind;
          in_tdata  <= {4'b0000, next_req.val, next_req.pos};
          if (!quiet_tail) begin
            if (send_calm > 0) begin
              send_calm--;
            end else if ($urandom_range(0, 5) == 0) begin
              send_gap = $urandom_range(1, 7);
              if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(20, 80);
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off once, long enough for the unit to stall its input.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && accepted_reqs >= HOLD_AT) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[1:0];
        got.removed = out_tdata[33:2];
        got.count   = out_tdata[38:34];
        status_seen[got.status]++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.removed != want.removed) begin
            $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                     $time, $signed(want.removed), $signed(got.removed));
            errors++;
          end
          if (got.count != want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, got.count);
            errors++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 6);
        out_tready <= 1'b0;
        if ($urandom_range(0, 7) == 0) recv_calm = $urandom_range(20, 80);
      end else begin
        if (recv_calm > 0) recv_calm--;
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("shift_list_insert_delete_unit test failed");
      $finish;
    end
  end

  initial begin
    int phase_caps [9];
    int p;
    int k;
    int n;
    phase_caps = '{16, 31, 5, 1, 24, 16, 0, 10, 16};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // With no room at all, every append and insert is refused.
    write_capacity(5'd0);
    @(negedge clk);
    queue_request(KIND_APPEND, 4'd0, 32'h7FFF_FFFF);
    queue_request(KIND_INSERT, 4'd0, 32'h1234_5678);
    queue_request(KIND_INSERT, 4'd1, 32'h1234_5678);
    queue_request(KIND_DELETE, 4'd0, 32'h0);
    queue_request(KIND_UNUSED, 4'd15, 32'hAAAA_AAAA);
    wait_drained;

    // A capacity above the built depth saturates.
    write_capacity(5'd31);
    @(negedge clk);
    queue_request(KIND_APPEND, 4'd9, 32'h8000_0000);
    queue_request(KIND_APPEND, 4'd0, 32'h7FFF_FFFF);
    queue_request(KIND_INSERT, 4'd0, 32'hFFFF_FFFF);
    queue_request(KIND_INSERT, 4'd3, 32'h0000_0000);
    queue_request(KIND_INSERT, 4'd2, 32'h5555_5555);
    queue_request(KIND_INSERT, 4'd15, 32'h0F0F_0F0F);
    queue_request(KIND_DELETE, 4'd0, 32'hFFFF_FFFF);
    queue_request(KIND_DELETE, 4'd15, 32'h0);
    queue_request(KIND_UNUSED, 4'd15, 32'hAAAA_AAAA);
    queue_request(KIND_DELETE, 4'd2, 32'h0);
    queue_request(KIND_APPEND, 4'd15, 32'h0000_0001);
    wait_drained;

    // Capacity below the count: growth is refused, deletion still works.
    write_capacity(5'd1);
    @(negedge clk);
    queue_request(KIND_APPEND, 4'd0, 32'h2222_2222);
    queue_request(KIND_INSERT, 4'd0, 32'h3333_3333);
    queue_request(KIND_INSERT, 4'd15, 32'h4444_4444);
    queue_request(KIND_DELETE, 4'd0, 32'h0);

    for (p = 0; p < 9; p++) begin
      wait_drained;
      write_capacity(phase_caps[p][4:0]);
      if (p == 8) quiet_tail <= 1'b1;
      @(negedge clk);
      n = (phase_caps[p] == 0) ? 60 : 205;
      for (k = 0; k < n; k++) pending_reqs.push_back(random_request((k / 40) % 2 == 0));
    end

    wait_drained;
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      errors++;
    end
    $display("Covered %0d requests over %0d capacity writes; done/full/range results %0d/%0d/%0d.",
             accepted_reqs, cap_writes, status_seen[ST_DONE], status_seen[ST_FULL],
             status_seen[ST_RANGE]);
    $display("One %0d-cycle receiver hold-off and a full drain before every capacity write.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("shift_list_insert_delete_unit test passed");
    end else begin
      $display("shift_list_insert_delete_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/shift_list_insert_delete_unit.sv
test/testbench.sv
